[hw/rtl/ahdlc_pkg.sv]
// Shared types, constants and the FCS-16 byte update for the async HDLC receiver.
// No dependencies; used by ahdlc_deframer, ahdlc_frame_receiver, ahdlc_checker and testbench.
package ahdlc_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7e;
    localparam logic [7:0]  ESC_BYTE  = 8'h7d;
    localparam logic [7:0]  ESC_XOR   = 8'h20;

    localparam logic [15:0] FCS_POLY  = 16'h8408;
    localparam logic [15:0] FCS_INIT  = 16'hffff;
    localparam logic [15:0] FCS_GOOD  = 16'hf0b8;

    localparam int          CFG_W         = 14;
    localparam int          LEN_W         = 14;
    localparam int          MAX_FRAME_DEF = 8192;
    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 14'd8192;

    // APB: one 32-bit register, word index taken from paddr[2]
    localparam int          APB_AW          = 3;
    localparam int          APB_DW          = 32;
    localparam logic        REG_IDX_MAX_LEN = 1'b0;

    // data_byte, frame_status, payload_len packed from bit 0 up
    localparam int          OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_BAD_FCS  = 2'd1,
        ST_OVERRUN  = 2'd2,
        ST_BAD_ESC  = 2'd3
    } t_status;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        t_status          status;
        logic             is_end;
        logic [7:0]       data;
    } t_result;

    // Reflected CRC-16 over one byte, LSB first
    function automatic logic [15:0] fcs_update(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {8'h00, d};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/ahdlc_deframer.sv]
// Frame state of the receiver: flag/escape handling, FCS check, two-byte hold-back.
// Depends on ahdlc_pkg. One byte per cycle, result is combinational to the caller.
module ahdlc_deframer
    import ahdlc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_max_len,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output t_result          o_res
);

    localparam int RAW_W_FULL = $clog2(MAX_FRAME + 1);
    localparam int RAW_W      = (RAW_W_FULL < CFG_W) ? RAW_W_FULL : CFG_W;

    logic             r_esc, n_esc;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_held0, n_held0;
    logic [7:0]       r_held1, n_held1;
    logic [1:0]       r_held_cnt, n_held_cnt;
    logic [RAW_W-1:0] r_raw, n_raw;
    logic [LEN_W-1:0] r_pay, n_pay;
    logic             r_ovr, n_ovr;

    logic [RAW_W-1:0] limit;
    logic [7:0]       d;
    logic             do_proc;

    always_comb begin
        if (32'(i_max_len) > 32'(MAX_FRAME)) begin
            limit = RAW_W'(MAX_FRAME);
        end else begin
            limit = RAW_W'(i_max_len);
        end
    end

    always_comb begin
        n_esc       = r_esc;
        n_crc       = r_crc;
        n_held0     = r_held0;
        n_held1     = r_held1;
        n_held_cnt  = r_held_cnt;
        n_raw       = r_raw;
        n_pay       = r_pay;
        n_ovr       = r_ovr;
        o_res_valid = 1'b0;
        o_res       = '0;
        d           = i_byte;
        do_proc     = 1'b0;

        if (i_valid) begin
            if (i_byte == FLAG_BYTE) begin
                // empty frames between adjacent flags give nothing
                if (r_raw != '0 || r_ovr) begin
                    o_res_valid  = 1'b1;
                    o_res.is_end = 1'b1;
                    o_res.len    = r_pay;
                    if (r_ovr) begin
                        o_res.status = ST_OVERRUN;
                    end else if (r_esc) begin
                        o_res.status = ST_BAD_ESC;
                    end else if (r_crc == FCS_GOOD) begin
                        o_res.status = ST_GOOD;
                    end else begin
                        o_res.status = ST_BAD_FCS;
                    end
                end
                n_esc      = 1'b0;
                n_crc      = FCS_INIT;
                n_held_cnt = 2'd0;
                n_raw      = '0;
                n_pay      = '0;
                n_ovr      = 1'b0;
            end else if (r_raw >= limit) begin
                n_ovr = 1'b1;
            end else begin
                n_raw = r_raw + 1'b1;
                if (r_esc) begin
                    n_esc   = 1'b0;
                    d       = i_byte ^ ESC_XOR;
                    do_proc = 1'b1;
                end else if (i_byte == ESC_BYTE) begin
                    n_esc = 1'b1;
                end else begin
                    do_proc = 1'b1;
                end

                if (do_proc) begin
                    n_crc = fcs_update(r_crc, d);
                    // the last two bytes are the FCS, so output lags by two
                    if (r_held_cnt == 2'd2) begin
                        o_res_valid = 1'b1;
                        o_res.data  = r_held0;
                        n_held0     = r_held1;
                        n_held1     = d;
                        if (r_pay != '1) begin
                            n_pay = r_pay + 1'b1;
                        end
                    end else if (r_held_cnt == 2'd0) begin
                        n_held0    = d;
                        n_held_cnt = 2'd1;
                    end else begin
                        n_held1    = d;
                        n_held_cnt = 2'd2;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc      <= 1'b0;
            r_crc      <= FCS_INIT;
            r_held_cnt <= 2'd0;
            r_raw      <= '0;
            r_pay      <= '0;
            r_ovr      <= 1'b0;
        end else begin
            r_esc      <= n_esc;
            r_crc      <= n_crc;
            r_held_cnt <= n_held_cnt;
            r_raw      <= n_raw;
            r_pay      <= n_pay;
            r_ovr      <= n_ovr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held0 <= n_held0;
        r_held1 <= n_held1;
    end

endmodule

[hw/rtl/ahdlc_frame_receiver.sv]
// Async HDLC (PPP-style) receiver: APB register, deframer and output skid buffer.
// Depends on ahdlc_pkg and ahdlc_deframer.
//
// Usage:
//   Raw line bytes enter on the slave stream (i_s_tdata[7:0]). Each accepted
//   byte is processed in the cycle it is taken; any result it causes is
//   registered in the output register, or in the skid entry if that one is held.
//   Payload bytes appear two decoded bytes late, so the FCS is never passed on.
//   A flag closing a non-empty frame yields one item with o_m_tlast high,
//   carrying the status (good, bad FCS, overrun, escape before flag) and the
//   payload length; payload items carry zero status and length.
//   Throughput: one byte per cycle while o_s_tready is high.
//   A two-entry output stage (register plus skid) lets input continue while a
//   result waits; o_s_tready drops only when both entries are full.
//   max_frame_len sits at APB byte address 0; it is to be written while idle,
//   which the block itself does not enforce. Synchronous reset clears all frame
//   state, sets max_frame_len to 8192 and starts inside a frame; no clearing pass is needed.
module ahdlc_frame_receiver
    import ahdlc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready,

    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,   // [7:0] rx_byte

    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [7:0] data_byte, [9:8] frame_status,
                                                // [23:10] payload_len
    output logic                   o_m_tlast    // is_end
);

    logic [CFG_W-1:0] r_max_len;
    logic             cfg_wr;

    logic             s_fire;
    logic             res_valid;
    t_result          res;

    logic             r_out_valid;
    t_result          r_out;
    logic             r_skid_valid;
    t_result          r_skid;
    logic             out_pop;

    // Configuration
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_IDX_MAX_LEN);
    assign prdata = (paddr[2] == REG_IDX_MAX_LEN) ? APB_DW'(r_max_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (cfg_wr) begin
            r_max_len <= pwdata[CFG_W-1:0];
        end
    end

    assign o_s_tready = ~r_skid_valid;
    assign s_fire     = i_s_tvalid & o_s_tready;

    ahdlc_deframer #(
        .MAX_FRAME (MAX_FRAME)
    ) u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_len   (r_max_len),
        .i_valid     (s_fire),
        .i_byte      (i_s_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register with skid entry
    assign out_pop = r_out_valid & i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (res_valid) begin
                if (!r_out_valid || out_pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out.is_end;
    assign o_m_tdata  = {r_out.len, r_out.status, r_out.data};

    // Skid entry is only ever filled behind an occupied output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // Payload items carry no status or length
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (o_m_tdata[OUT_TDATA_W-1:8] == '0))
        else $error("payload item with non-zero status or length");

    // A result arriving while both entries are busy would be lost
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready && res_valid) |-> !r_skid_valid)
        else $error("result produced with output stage full");

endmodule

[dv/ahdlc_checker.sv]
// Scoreboard for the async HDLC receiver: predicts every result from the accepted line bytes
// and compares it with the output stream. Depends on ahdlc_pkg; holds ahdlc_tb_pkg for the FCS.
package ahdlc_tb_pkg;

    // FCS-16, reflected, one byte shifted in LSB first
    function automatic logic [15:0] fcs16_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] r;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ d[i]) begin
                r = (r >> 1) ^ ahdlc_pkg::FCS_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

module ahdlc_checker
    import ahdlc_pkg::*;
    import ahdlc_tb_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic                   i_pready,
    input  logic [APB_AW-1:0]      i_paddr,
    input  logic [APB_DW-1:0]      i_pwdata,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [7:0]             i_in_byte,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [OUT_TDATA_W-1:0] i_out_data,
    input  logic                   i_out_last,
    output int                     o_fail_count,
    output int                     o_results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        t_status          status;
        logic             is_end;
        logic [7:0]       data;
    } t_rx_result;

    t_rx_result        rx_results_due[$];

    // shadow of the receiver
    logic [CFG_W-1:0]  frame_limit_reg;
    logic              esc_open;
    logic [15:0]       fcs_acc;
    logic [7:0]        delay_line [2];
    logic [1:0]        delay_fill;
    logic [CFG_W-1:0]  raw_bytes;
    logic [LEN_W-1:0]  payload_bytes;
    logic              overrun_flag;
    logic              bad_esc_flag;

    initial o_fail_count = 0;
    initial o_results_due = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < 100) begin
            $display("ERROR %0t: %s: got %0h, want %0h", $realtime, what, got, want);
        end
        o_fail_count++;
    endtask

    task automatic close_frame();
        esc_open = 1'b0;
        fcs_acc = FCS_INIT;
        delay_fill = '0;
        raw_bytes = '0;
        payload_bytes = '0;
        overrun_flag = 1'b0;
        bad_esc_flag = 1'b0;
    endtask

    task automatic predict_rx_byte(input logic [7:0] b);
        t_rx_result        r;
        logic [7:0]        d;
        logic [CFG_W-1:0]  lim;
        lim = (frame_limit_reg > MAX_FRAME) ? CFG_W'(MAX_FRAME) : frame_limit_reg;
        r = '0;
        if (b == FLAG_BYTE) begin
            // a flag with nothing since the last one closes an empty frame silently
            if (raw_bytes == 0 && !overrun_flag) begin
                close_frame();
                return;
            end
            if (esc_open) bad_esc_flag = 1'b1;
            if (overrun_flag)            r.status = ST_OVERRUN;
            else if (bad_esc_flag)       r.status = ST_BAD_ESC;
            else if (fcs_acc == FCS_GOOD) r.status = ST_GOOD;
            else                         r.status = ST_BAD_FCS;
            r.is_end = 1'b1;
            r.len = payload_bytes;
            rx_results_due.push_back(r);
            close_frame();
            return;
        end
        if (raw_bytes >= lim) begin
            overrun_flag = 1'b1;
            return;
        end
        raw_bytes++;
        if (esc_open) begin
            esc_open = 1'b0;
            d = b ^ ESC_XOR;
        end else if (b == ESC_BYTE) begin
            esc_open = 1'b1;
            return;
        end else begin
            d = b;
        end
        fcs_acc = fcs16_byte(fcs_acc, d);
        if (delay_fill >= 2) begin
            r.data = delay_line[0];
            delay_line[0] = delay_line[1];
            delay_line[1] = d;
            if (payload_bytes != {LEN_W{1'b1}}) payload_bytes++;
            rx_results_due.push_back(r);
        end else begin
            delay_line[delay_fill[0]] = d;
            delay_fill++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rx_result want;
        if (!i_rst_n) begin
            frame_limit_reg = MAX_LEN_RESET;
            delay_line[0] = '0;
            delay_line[1] = '0;
            close_frame();
            rx_results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (rx_results_due.size() == 0) begin
                    report_mismatch("result with nothing due", {i_out_last, i_out_data}, 0);
                end else begin
                    want = rx_results_due.pop_front();
                    if (i_out_last != want.is_end)
                        report_mismatch("end flag", i_out_last, want.is_end);
                    if (i_out_data[7:0] != want.data)
                        report_mismatch("data byte", i_out_data[7:0], want.data);
                    if (i_out_data[9:8] != want.status)
                        report_mismatch("frame status", i_out_data[9:8], want.status);
                    if (i_out_data[23:10] != want.len)
                        report_mismatch("payload length", i_out_data[23:10], want.len);
                end
            end
            // a byte taken at the same edge as a register write still sees the old limit
            if (i_in_valid && i_in_ready) predict_rx_byte(i_in_byte);
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_IDX_MAX_LEN)
                frame_limit_reg = i_pwdata[CFG_W-1:0];
        end
        o_results_due = rx_results_due.size();
    end

endmodule

[dv/testbench.sv]
// Top of the async HDLC receiver bench: clock, reset, APB writes, line-byte stimulus and verdict.
// Depends on ahdlc_pkg, ahdlc_tb_pkg, ahdlc_checker and ahdlc_frame_receiver.
module testbench;
    import ahdlc_pkg::*;
    import ahdlc_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    typedef logic [7:0] t_byte_q[$];

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [APB_DW-1:0]      pwdata = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata = '0;   // [7:0] rx_byte
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;        // [7:0] data_byte, [9:8] frame_status,
                                              // [23:10] payload_len
    logic                   o_m_tlast;        // is_end

    int fail_count;
    int results_due;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    ahdlc_frame_receiver DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    ahdlc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_in_valid    (i_s_tvalid),
        .i_in_ready    (o_s_tready),
        .i_in_byte     (i_s_tdata),
        .i_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .i_out_data    (o_m_tdata),
        .i_out_last    (o_m_tlast),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    // result side: random back-pressure, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge once the byte is taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_max_len(input logic [CFG_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_IDX_MAX_LEN, 2'b00};
        pwdata <= APB_DW'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (results_due != 0) @(negedge i_clk);
        // bytes that cause no result may still be in flight
        repeat (4) @(negedge i_clk);
    endtask

    // payload plus FCS, stuffed; optionally one bit spoiled or an escape left before the flag
    task automatic send_frame(input t_byte_q body, input bit spoil, input bit esc_tail);
        logic [15:0] fcs;
        int          pos;
        fcs = FCS_INIT;
        foreach (body[j]) fcs = fcs16_byte(fcs, body[j]);
        fcs = ~fcs;
        body.push_back(fcs[7:0]);
        body.push_back(fcs[15:8]);
        if (spoil) begin
            pos = $urandom_range(body.size() - 1);
            body[pos] = body[pos] ^ (8'h01 << $urandom_range(7));
        end
        foreach (body[j]) begin
            // any byte may be escaped, except one whose escaped form is a flag
            if (body[j] == FLAG_BYTE || body[j] == ESC_BYTE ||
                (body[j] != (FLAG_BYTE ^ ESC_XOR) && $urandom_range(9) == 0)) begin
                send_byte(ESC_BYTE);
                send_byte(body[j] ^ ESC_XOR);
            end else begin
                send_byte(body[j]);
            end
        end
        if (esc_tail) send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE);
    endtask

    task automatic send_random_traffic(input int n_bytes);
        t_byte_q body;
        int      stop_at;
        int      pick;
        int      len;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 10);
            body.delete();
            for (int k = 0; k < len; k++) body.push_back(8'($urandom_range(255)));
            if (pick < 68) begin
                send_frame(body, 1'b0, 1'b0);
            end else if (pick < 80) begin
                send_frame(body, 1'b1, 1'b0);
            end else if (pick < 86) begin
                send_frame(body, 1'b0, 1'b1);
            end else if (pick < 94) begin
                // line noise, flags and escapes included by chance
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
                if ($urandom_range(1)) send_byte(FLAG_BYTE);
            end else begin
                send_byte(FLAG_BYTE);
            end
        end
    endtask

    initial begin
        t_byte_q body;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sender sparse-ish, receiver mostly stalled
        tx_idle_pct = 27;
        rx_idle_pct = 75;
        send_byte(FLAG_BYTE);                       // empty frame straight after reset
        body = '{8'h00, 8'hff, FLAG_BYTE, ESC_BYTE};
        send_frame(body, 1'b0, 1'b0);
        send_byte(FLAG_BYTE);                       // flag after flag
        send_byte(8'h41);                           // one-byte frame
        send_byte(FLAG_BYTE);
        send_byte(8'h11);                           // escape then flag
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE);
        send_byte(ESC_BYTE);                        // double escape, then escaped plain byte
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE);
        send_byte(8'h41);
        send_byte(8'h33);
        send_byte(8'h44);
        send_byte(FLAG_BYTE);
        send_random_traffic(230);
        wait_idle();

        // shortest limit: overruns everywhere
        write_max_len(CFG_W'(3));
        tx_idle_pct = 75;
        rx_idle_pct = 27;
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        send_byte(8'h04);                           // dropped, frame overruns
        send_byte(FLAG_BYTE);
        send_random_traffic(220);
        wait_idle();

        // full limit, no idling, one long hold-off so the input stalls
        write_max_len(CFG_W'(MAX_FRAME_DEF));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req++;
        send_random_traffic(200);
        wait_idle();

        write_max_len(CFG_W'($urandom_range(4, 40)));
        send_random_traffic(200);
        wait_idle();

        repeat (16) @(negedge i_clk);
        if (fail_count == 0 && results_due == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
